[src/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the single-source shortest path engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

	localparam int MAX_VERTICES_DEF = 32;
	localparam int WEIGHT_BITS_DEF  = 16;

	localparam int VTX_W      = 5;
	localparam int WGT_W      = 16;
	localparam int DIST_W     = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [DIST_W-1:0] UNREACH = DIST_W'(99999);

	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_RUN  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 2'd1;

	typedef struct packed {
		logic             kind;
		logic [VTX_W-1:0] from_vertex;
		logic [VTX_W-1:0] to_vertex;
		logic [WGT_W-1:0] weight;
	} item_t;

	typedef struct packed {
		logic [VTX_W-1:0]  vertex;
		logic [DIST_W-1:0] distance;
		logic              reachable;
		logic              last;
	} result_t;

	typedef struct packed {
		logic              add_weight;
		logic [DIST_W-1:0] base;
		logic [WGT_W-1:0]  weight;
	} alu_op_t;

endpackage

`default_nettype wire

[src/single_source_shortest_paths.sv]
// ----------------------------------------------------------------------------
// single_source_shortest_paths
// Dense Dijkstra engine over an on-chip adjacency matrix.
// ----------------------------------------------------------------------------
// usage:
//   an item is taken when start is high and busy is low. an edge word writes
//   one matrix weight in the accept cycle and leaves busy low, so edge words
//   can stream one per cycle. a run word raises busy until its results are out.
//   results come one per vertex on result with result_valid high for one cycle,
//   vertex 0 first, last set on the final one; the receiver cannot stall.
//   a run over n vertices: an init pass, then n rounds of a scan pass and a
//   relax pass, then an emit pass plus one output register. scan and relax
//   share the distance ram read port and the add/compare unit, so they run
//   as separate passes. the first result comes after the emit pass's ram
//   read and the output register.
//   configuration words (cfg_valid/cfg_ready, always ready) are taken anytime.
//   the vertex count takes effect at the next run; the source vertex is read during the init pass.
//   after reset the matrix is cleared one entry per cycle, all
//   2^(2*clog2(max vertices)) entries (1024 by default), with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module single_source_shortest_paths import ssp_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	output logic                  result_valid,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int VIDX_W     = $clog2(MAX_VERTICES);
	localparam int CNT_W      = $clog2(MAX_VERTICES + 1);
	localparam int EA_W       = 2 * VIDX_W;
	localparam int EDGE_DEPTH = 1 << EA_W;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_INIT  = 6'b000100,
		S_SCAN  = 6'b001000,
		S_RELAX = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t                  state_q;
	logic [CFG_DATA_W-1:0]   vertex_count_q;
	logic [VTX_W-1:0]        source_q;
	logic [CNT_W-1:0]        n_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        round_q;
	logic [VIDX_W-1:0]       best_q;
	logic [DIST_W-1:0]       bestd_q;
	logic [EA_W-1:0]         clr_q;
	logic                    rd_vld_s1;
	logic [VIDX_W-1:0]       idx_s1;
	logic                    res_valid_q;
	result_t                 res_q;

	logic [CNT_W-1:0]        n_next;
	logic [VIDX_W-1:0]       rd_idx;
	logic [VIDX_W-1:0]       last_idx;
	logic                    issue;
	logic                    stage_last;
	logic                    accept;
	logic                    edge_ok;

	logic                    edge_we;
	logic [EA_W-1:0]         edge_waddr;
	logic [WEIGHT_BITS-1:0]  edge_wdata;
	logic [WEIGHT_BITS-1:0]  w_s1;

	logic                    dist_we;
	logic [VIDX_W-1:0]       dist_waddr;
	logic [DIST_W:0]         dist_wdata;
	logic [DIST_W:0]         dist_rdata;
	logic [DIST_W-1:0]       d_s1;
	logic                    settled_s1;

	alu_op_t                 alu_op;
	logic [DIST_W:0]         alu_sum;
	logic                    alu_lt;
	logic                    scan_take;

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign accept       = start && !busy;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign rd_idx     = cnt_q[VIDX_W-1:0];
	assign last_idx   = VIDX_W'(n_q - 1'b1);
	assign d_s1       = dist_rdata[DIST_W-1:0];
	assign settled_s1 = dist_rdata[DIST_W];
	assign stage_last = rd_vld_s1 && (idx_s1 == last_idx);
	assign issue      = ((state_q == S_SCAN) || (state_q == S_RELAX) || (state_q == S_EMIT))
		&& (cnt_q < n_q);
	assign edge_ok    = (32'(item.from_vertex) < MAX_VERTICES)
		&& (32'(item.to_vertex) < MAX_VERTICES);

	always_comb begin
		if (vertex_count_q == '0) begin
			n_next = CNT_W'(1);
		end else if (32'(vertex_count_q) > MAX_VERTICES) begin
			n_next = CNT_W'(MAX_VERTICES);
		end else begin
			n_next = CNT_W'(vertex_count_q);
		end
	end

	// shared add/compare unit
	assign alu_op.add_weight = (state_q == S_RELAX);
	assign alu_op.base       = bestd_q;
	assign alu_op.weight     = WGT_W'(w_s1);
	assign scan_take         = rd_vld_s1 && !settled_s1 && !alu_lt;

	ssp_alu u_alu (
		.op       (alu_op),
		.cur_dist (d_s1),
		.sum      (alu_sum),
		.lt       (alu_lt)
	);

	// matrix write port: clearing pass or edge word
	always_comb begin
		edge_we    = 1'b0;
		edge_waddr = clr_q;
		edge_wdata = '0;
		if (state_q == S_CLEAR) begin
			edge_we = 1'b1;
		end else if (accept && (item.kind == KIND_EDGE) && edge_ok) begin
			edge_we    = 1'b1;
			edge_waddr = {VIDX_W'(item.from_vertex), VIDX_W'(item.to_vertex)};
			edge_wdata = WEIGHT_BITS'(item.weight);
		end
	end

	// distance ram write port
	always_comb begin
		dist_we    = 1'b0;
		dist_waddr = rd_idx;
		dist_wdata = {1'b0, UNREACH};
		case (state_q)
			S_INIT: begin
				dist_we = 1'b1;
				if (32'(cnt_q) == 32'(source_q)) begin
					dist_wdata = '0;
				end
			end
			S_RELAX: begin
				dist_waddr = idx_s1;
				if (rd_vld_s1 && (idx_s1 == best_q)) begin
					dist_we    = 1'b1;
					dist_wdata = {1'b1, d_s1};
				end else if (rd_vld_s1 && !settled_s1 && (w_s1 != '0)
					&& (bestd_q != UNREACH) && alu_lt) begin
					dist_we    = 1'b1;
					dist_wdata = {1'b0, alu_sum[DIST_W-1:0]};
				end
			end
			default: begin
				dist_we = 1'b0;
			end
		endcase
	end

	ssp_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (EDGE_DEPTH)
	) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (edge_wdata),
		.raddr ({best_q, rd_idx}),
		.rdata (w_s1)
	);

	ssp_ram #(
		.WIDTH (DIST_W + 1),
		.DEPTH (MAX_VERTICES)
	) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (rd_idx),
		.rdata (dist_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= CFG_DATA_W'(32);
			source_q       <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VERTEX_COUNT:  vertex_count_q <= cfg_data;
				REG_SOURCE_VERTEX: source_q       <= cfg_data[VTX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (state_q == S_EMIT) && rd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		res_q.vertex    <= VTX_W'(idx_s1);
		res_q.distance  <= d_s1;
		res_q.reachable <= d_s1 < UNREACH;
		res_q.last      <= idx_s1 == last_idx;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			n_q       <= '0;
			cnt_q     <= '0;
			round_q   <= '0;
			best_q    <= '0;
			bestd_q   <= UNREACH;
			rd_vld_s1 <= 1'b0;
			idx_s1    <= '0;
		end else begin
			rd_vld_s1 <= issue;
			idx_s1    <= rd_idx;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && (item.kind == KIND_RUN)) begin
						n_q     <= n_next;
						cnt_q   <= '0;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == n_q - 1'b1) begin
						cnt_q   <= '0;
						round_q <= '0;
						best_q  <= '0;
						bestd_q <= UNREACH;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_take) begin
						best_q  <= idx_s1;
						bestd_q <= d_s1;
					end
					if (stage_last) begin
						cnt_q   <= '0;
						state_q <= S_RELAX;
					end
				end
				S_RELAX: begin
					if (stage_last) begin
						cnt_q   <= '0;
						round_q <= round_q + 1'b1;
						best_q  <= '0;
						bestd_q <= UNREACH;
						if (round_q == n_q - 1'b1) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_EMIT: begin
					if (stage_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a result word only follows an emit cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> $past(state_q == S_EMIT))
		else $error("result word outside emit pass");

	// the final word of a run is never followed by another in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.last) |=> !res_valid_q)
		else $error("result word after last");

	// a relaxation only ever lowers a distance
	assert property (@(posedge clk) disable iff (!arst_n)
		(dist_we && (state_q == S_RELAX) && !dist_wdata[DIST_W])
		|-> (dist_wdata[DIST_W-1:0] < d_s1))
		else $error("relaxation raised a distance");

	// nothing in flight in the read pipeline while idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !rd_vld_s1)
		else $error("read pipeline busy while idle");

	// the settled vertex of a round is never already settled when rewritten
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RELAX) && rd_vld_s1 && (idx_s1 == best_q) && (bestd_q != UNREACH))
		|-> !settled_s1)
		else $error("picked vertex was already settled");

endmodule

`default_nettype wire

[src/ssp_ram.sv]
// ----------------------------------------------------------------------------
// ssp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[src/ssp_alu.sv]
// ----------------------------------------------------------------------------
// ssp_alu
// Shared add and compare unit: base plus optional weight, checked against
// a stored distance. Serves both the minimum scan and edge relaxation.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_alu import ssp_pkg::*; (
	input  alu_op_t           op,
	input  logic [DIST_W-1:0] cur_dist,
	output logic [DIST_W:0]   sum,
	output logic              lt
);

	always_comb begin
		sum = {1'b0, op.base} + (op.add_weight ? (DIST_W+1)'(op.weight) : '0);
		lt  = sum < {1'b0, cur_dist};
	end

endmodule

`default_nettype wire
